/* rtl/core/scpr_pkg.sv */
`timescale 1ns / 1ps

package scpr_pkg;

    // Storage sizing.
    localparam int FRAME_SLOTS = 8;
    localparam int PAGE_BITS   = 16;

    // Fixed field widths of the channels.
    localparam int PAGE_NUM_W   = 16;
    localparam int FRAME_SLOT_W = 3;
    localparam int FAULT_W      = 16;
    localparam int CFG_W        = 4;

    localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(8);
    localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

    // Frame index width and a count width that can hold FRAME_SLOTS and any
    // configured value.
    localparam int SLOT_W  = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
    localparam int CNT_RAW = $clog2(FRAME_SLOTS + 1);
    localparam int CNT_W   = (CFG_W > CNT_RAW) ? CFG_W : CNT_RAW;

    typedef struct packed {
        logic capture;
        logic lookup;
        logic sweep;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic hit;
        logic ref_at_hand;
    } t_dp_sts;

endpackage

/* rtl/core/scpr_ctrl.sv */
`timescale 1ns / 1ps

module scpr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    output logic              o_valid,
    input  logic              i_stall,
    input  scpr_pkg::t_dp_sts i_sts,
    output scpr_pkg::t_dp_cmd o_cmd
);
    import scpr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_LOOKUP = 4'b0010,
        S_SWEEP  = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_out_valid;
    logic    n_out_valid;
    t_dp_cmd cmd;

    always_comb begin
        n_state     = r_state;
        cmd         = '0;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    cmd.capture = 1'b1;
                    n_state     = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                cmd.lookup = 1'b1;
                n_state    = i_sts.hit ? S_FINISH : S_SWEEP;
            end
            S_SWEEP: begin
                // The hand moves one frame per cycle until it meets a clear
                // reference bit, where the page is placed.
                cmd.sweep = 1'b1;
                if (!i_sts.ref_at_hand) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || !i_stall) begin
                    cmd.load_out = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_cmd   = cmd;

`ifndef SYNTHESIS
    a_accept_to_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == S_LOOKUP))
        else $error("accepted word did not start a lookup");

    a_hit_skips_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOKUP && i_sts.hit) |=> (r_state == S_FINISH))
        else $error("hit entered the sweep");

    a_load_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |=> o_valid)
        else $error("loaded result not presented");
`endif

endmodule

/* rtl/core/scpr_dp.sv */
`timescale 1ns / 1ps

module scpr_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [scpr_pkg::CFG_W-1:0]           i_cfg_wdata,
    input  logic [scpr_pkg::PAGE_NUM_W-1:0]      i_page_number,
    input  scpr_pkg::t_dp_cmd                    i_cmd,
    output scpr_pkg::t_dp_sts                    o_sts,
    output logic                                 o_hit,
    output logic [scpr_pkg::FRAME_SLOT_W-1:0]    o_frame_slot,
    output logic                                 o_evicted_valid,
    output logic [scpr_pkg::PAGE_NUM_W-1:0]      o_evicted_page,
    output logic [scpr_pkg::FAULT_W-1:0]         o_fault_count
);
    import scpr_pkg::*;

    // Frame table and clock state.
    logic [PAGE_BITS-1:0] r_pages [FRAME_SLOTS];
    logic [FRAME_SLOTS-1:0] r_frame_valid;
    logic [FRAME_SLOTS-1:0] r_ref;
    logic [SLOT_W-1:0]      r_hand;
    logic [FAULT_W-1:0]     r_faults;
    logic [CFG_W-1:0]       r_cfg;

    // Per-word working registers.
    logic [PAGE_BITS-1:0] r_page;
    logic [SLOT_W-1:0]    r_sweep;
    logic                 r_hit;
    logic [SLOT_W-1:0]    r_slot;
    logic                 r_ev_valid;
    logic [PAGE_BITS-1:0] r_ev_page;

    // Output word.
    logic                    r_out_hit;
    logic [FRAME_SLOT_W-1:0] r_out_slot;
    logic                    r_out_ev_valid;
    logic [PAGE_NUM_W-1:0]   r_out_ev_page;
    logic [FAULT_W-1:0]      r_out_faults;

    logic [CNT_W-1:0]  cfg_ext;
    logic [CNT_W-1:0]  active_n;
    logic              hit;
    logic [SLOT_W-1:0] hit_slot;
    logic [SLOT_W-1:0] start_hand;
    logic [SLOT_W-1:0] sweep_next;
    logic [SLOT_W-1:0] hand_next;
    logic              ref_at_hand;

    function automatic logic [SLOT_W-1:0] next_slot(
        input logic [SLOT_W-1:0] slot,
        input logic [CNT_W-1:0]  count
    );
        logic [CNT_W-1:0] s;
        s = CNT_W'(slot) + CNT_W'(1);
        return (s >= count) ? '0 : SLOT_W'(s);
    endfunction

    // A frame count of zero acts as one, and one above the table size as the
    // table size.
    assign cfg_ext = CNT_W'(r_cfg);
    always_comb begin
        if (cfg_ext == '0) begin
            active_n = CNT_W'(1);
        end else if (cfg_ext > CNT_W'(FRAME_SLOTS)) begin
            active_n = CNT_W'(FRAME_SLOTS);
        end else begin
            active_n = cfg_ext;
        end
    end

    // Parallel compare over the active frames; the lowest matching frame wins.
    always_comb begin
        hit      = 1'b0;
        hit_slot = '0;
        for (int i = FRAME_SLOTS - 1; i >= 0; i--) begin
            if (r_frame_valid[i] && (r_pages[i] == r_page) && (CNT_W'(i) < active_n)) begin
                hit      = 1'b1;
                hit_slot = SLOT_W'(i);
            end
        end
    end

    assign start_hand  = (CNT_W'(r_hand) >= active_n) ? '0 : r_hand;
    assign ref_at_hand = r_ref[r_sweep];
    assign sweep_next  = next_slot(r_sweep, active_n);
    assign hand_next   = sweep_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_valid <= '0;
            r_ref         <= '0;
            r_hand        <= '0;
            r_faults      <= '0;
            r_cfg         <= CFG_RESET;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            if (i_cmd.lookup && hit) begin
                r_ref[hit_slot] <= 1'b1;
            end
            if (i_cmd.sweep) begin
                if (ref_at_hand) begin
                    r_ref[r_sweep] <= 1'b0;
                end else begin
                    r_ref[r_sweep]         <= 1'b1;
                    r_frame_valid[r_sweep] <= 1'b1;
                    r_hand                 <= hand_next;
                    if (r_faults != FAULT_MAX) begin
                        r_faults <= r_faults + FAULT_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_page <= PAGE_BITS'(i_page_number);
        end
        if (i_cmd.lookup) begin
            r_hit      <= hit;
            r_slot     <= hit_slot;
            r_ev_valid <= 1'b0;
            r_ev_page  <= '0;
            r_sweep    <= start_hand;
        end
        if (i_cmd.sweep) begin
            if (ref_at_hand) begin
                r_sweep <= sweep_next;
            end else begin
                r_slot           <= r_sweep;
                r_ev_valid       <= r_frame_valid[r_sweep];
                r_ev_page        <= r_frame_valid[r_sweep] ? r_pages[r_sweep] : '0;
                r_pages[r_sweep] <= r_page;
            end
        end
        if (i_cmd.load_out) begin
            r_out_hit      <= r_hit;
            r_out_slot     <= FRAME_SLOT_W'(r_slot);
            r_out_ev_valid <= r_ev_valid;
            r_out_ev_page  <= PAGE_NUM_W'(r_ev_page);
            r_out_faults   <= r_faults;
        end
    end

    assign o_sts.hit         = hit;
    assign o_sts.ref_at_hand = ref_at_hand;

    assign o_hit           = r_out_hit;
    assign o_frame_slot    = r_out_slot;
    assign o_evicted_valid = r_out_ev_valid;
    assign o_evicted_page  = r_out_ev_page;
    assign o_fault_count   = r_out_faults;

`ifndef SYNTHESIS
    a_faults_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_faults >= $past(r_faults)))
        else $error("fault count went backward");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |=> (!r_out_hit || !r_out_ev_valid))
        else $error("hit reported an eviction");
`endif

endmodule

/* rtl/core/second_chance_page_replacement_unit.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Word
// input     in         i_valid / o_stall  i_page_number
// result    out        o_valid / i_stall  o_hit, o_frame_slot, o_evicted_valid,
//                                         o_evicted_page, o_fault_count
// config    in         i_cfg_we           i_cfg_wdata (frames in use)
//
// A hit goes through accept, parallel lookup and result load before the next word
// can be accepted. A miss adds a sweep step for each frame the clock hand visits,
// 1 to n+1 frames for n active frames.
// The sweep of the hand, one frame per cycle, sets the miss latency.
// Reset is synchronous and active low; it empties the frame table, zeroes the
// hand and the fault count, and sets the frame count to 8.
// The result sits in an output register, so a stalled result does not block
// the next accept; only loading a new result waits for that register.

module second_chance_page_replacement_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [scpr_pkg::CFG_W-1:0]           i_cfg_wdata,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [scpr_pkg::PAGE_NUM_W-1:0]      i_page_number,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic                                 o_hit,
    output logic [scpr_pkg::FRAME_SLOT_W-1:0]    o_frame_slot,
    output logic                                 o_evicted_valid,
    output logic [scpr_pkg::PAGE_NUM_W-1:0]      o_evicted_page,
    output logic [scpr_pkg::FAULT_W-1:0]         o_fault_count
);
    import scpr_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    scpr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    scpr_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_page_number   (i_page_number),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_hit           (o_hit),
        .o_frame_slot    (o_frame_slot),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page),
        .o_fault_count   (o_fault_count)
    );

endmodule
